// ===== rtl/core/phsds_pkg.sv =====
package phsds_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TABLE_DEPTH_DEF = 256;

  localparam logic [15:0] ETH_ARP = 16'h0806;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_REPLY = 16'd2;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [5:0] FLAGS_BARE_SYN = 6'h02;
  localparam logic [15:0] WATCHED_PORT_RST = 16'd80;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_ARP_REPLY = 2'd1;
  localparam logic [1:0] KIND_BARE_SYN = 2'd2;
  localparam logic [1:0] KIND_WATCHED = 2'd3;

  // search token handed from cell to cell
  typedef struct packed {
    logic tok;
    logic hit;
  } walk_t;

endpackage

// ===== rtl/core/phsds_cell.sv =====
module phsds_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CNT_W = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [phsds_pkg::ADDR_W-1:0]  query,
  input  logic [CNT_W-1:0]              count,
  input  logic                          wr_go,
  input  phsds_pkg::walk_t              walk_in,
  output phsds_pkg::walk_t              walk_out
);

  logic [phsds_pkg::ADDR_W-1:0] entry_r;
  logic                         live;
  logic                         tok_r;
  logic                         tok_nxt;
  logic                         hit_r;
  logic                         hit_nxt;

  // only entries below the fill count take part
  assign live = CNT_W'(IDX) < count;

  always_comb begin
    tok_nxt = walk_in.tok;
    hit_nxt = walk_in.hit | (walk_in.tok & live & (entry_r == query));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (wr_go && (count == CNT_W'(IDX))) begin
      entry_r <= query;
    end
  end

  assign walk_out.tok = tok_r;
  assign walk_out.hit = hit_r;

endmodule

// ===== rtl/core/packet_header_stats_distinct_sources_core.sv =====
// the result passes through the DECIDE and FINISH states to the registered out_tvalid;
// a bare syn also waits in SEARCH for the lookup token to walk along the cell row
// flow: one packet at a time; a new packet is taken while the previous result waits,
// and the next result waits for out_tready
// reset (synchronous, rst_n low): counters and fill count to zero, watched port to 80,
// table contents are left as they are and only filled entries are ever compared
module packet_header_stats_distinct_sources_core #(
  parameter int unsigned TABLE_DEPTH = phsds_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // eth_type[15:0] arp_opcode[31:16] ip_protocol[39:32] tcp_flags[45:40]
  // dest_port[61:46] source_addr[93:62]
  input  logic [95:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // new_source[0] table_full[1] syn_total[33:2] distinct_total[42:34]
  // arp_reply_total[74:43]
  output logic [79:0] out_tdata,
  // packet_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] watched_port_r;

  logic [15:0] eth_type_r;
  logic [15:0] arp_opcode_r;
  logic [7:0]  ip_protocol_r;
  logic [5:0]  tcp_flags_r;
  logic [15:0] dest_port_r;
  logic [phsds_pkg::ADDR_W-1:0] source_addr_r;
  logic        hit_r, hit_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0] syn_cnt_r, syn_cnt_nxt;
  logic [31:0] arp_cnt_r, arp_cnt_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        fresh_r, fresh_nxt;
  logic        full_r, full_nxt;
  logic [31:0] syn_out_r;
  logic [31:0] arp_out_r;
  logic [8:0]  dist_out_r, dist_nxt;
  logic [CNT_W+8:0] cnt_ext;

  logic in_xfer;
  logic out_free;
  logic finish_go;
  logic launch;
  logic is_arp_reply, is_tcp, is_bare_syn, is_watched;

  phsds_pkg::walk_t walk [TABLE_DEPTH+1];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;
  assign finish_go = (state_r == ST_FINISH) && out_free;

  assign is_arp_reply = (eth_type_r == phsds_pkg::ETH_ARP) &&
                        (arp_opcode_r == phsds_pkg::ARP_REPLY);
  assign is_tcp       = (eth_type_r == phsds_pkg::ETH_IPV4) &&
                        (ip_protocol_r == phsds_pkg::PROTO_TCP);
  assign is_bare_syn  = is_tcp && (tcp_flags_r == phsds_pkg::FLAGS_BARE_SYN);
  assign is_watched   = is_tcp && !is_bare_syn && (dest_port_r == watched_port_r);

  assign launch = (state_r == ST_DECIDE) && is_bare_syn;

  assign walk[0].tok = launch;
  assign walk[0].hit = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    phsds_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .query    (source_addr_r),
      .count    (cnt_r),
      .wr_go    (finish_go && fresh_nxt),
      .walk_in  (walk[i]),
      .walk_out (walk[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    hit_nxt   = hit_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        hit_nxt = 1'b0;
        if (is_bare_syn) begin
          state_nxt = ST_SEARCH;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (walk[TABLE_DEPTH].tok) begin
          hit_nxt   = walk[TABLE_DEPTH].hit;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (is_arp_reply) begin
      kind_nxt = phsds_pkg::KIND_ARP_REPLY;
    end else if (is_bare_syn) begin
      kind_nxt = phsds_pkg::KIND_BARE_SYN;
    end else if (is_watched) begin
      kind_nxt = phsds_pkg::KIND_WATCHED;
    end else begin
      kind_nxt = phsds_pkg::KIND_OTHER;
    end
    fresh_nxt   = is_bare_syn && !hit_r && (cnt_r < CNT_W'(TABLE_DEPTH));
    cnt_nxt     = fresh_nxt ? cnt_r + CNT_W'(1) : cnt_r;
    syn_cnt_nxt = is_bare_syn ? syn_cnt_r + 32'd1 : syn_cnt_r;
    arp_cnt_nxt = is_arp_reply ? arp_cnt_r + 32'd1 : arp_cnt_r;
    full_nxt    = (cnt_nxt == CNT_W'(TABLE_DEPTH));
    cnt_ext     = {9'd0, cnt_nxt};
    dist_nxt    = cnt_ext[8:0];
    if (finish_go) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      watched_port_r <= phsds_pkg::WATCHED_PORT_RST;
      cnt_r          <= '0;
      syn_cnt_r      <= '0;
      arp_cnt_r      <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        watched_port_r <= cfg_data;
      end
      if (finish_go) begin
        cnt_r     <= cnt_nxt;
        syn_cnt_r <= syn_cnt_nxt;
        arp_cnt_r <= arp_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    if (in_xfer) begin
      eth_type_r    <= in_tdata[15:0];
      arp_opcode_r  <= in_tdata[31:16];
      ip_protocol_r <= in_tdata[39:32];
      tcp_flags_r   <= in_tdata[45:40];
      dest_port_r   <= in_tdata[61:46];
      source_addr_r <= in_tdata[93:62];
    end
    if (finish_go) begin
      kind_r     <= kind_nxt;
      fresh_r    <= fresh_nxt;
      full_r     <= full_nxt;
      syn_out_r  <= syn_cnt_nxt;
      arp_out_r  <= arp_cnt_nxt;
      dist_out_r <= dist_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {5'd0, arp_out_r, dist_out_r, syn_out_r, full_r, fresh_r};

endmodule
